// File: sv/tid_pkg.sv
// Package for the tag identifier table: mode codes, default sizes,
// the cell control struct and the key normalization function.
// No dependencies.
`default_nettype none

package tid_pkg;

  // Default table depth and identifier length in bytes.
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned KEY_BYTES_DEF = 8;

  // Fixed payload widths.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 5;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic add_en;  // write the key into the cell at the fill position
    logic rem_en;  // cells at or after the first match take their neighbor's entry
  } cell_ctl_t;

  // Cut a raw key to kb bytes, then at its first zero byte.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw,
                                                input int unsigned kb);
    logic [KEY_W-1:0] k;
    logic             stop;
    logic [7:0]       byte_v;
    k    = '0;
    stop = 1'b0;
    for (int unsigned b = 0; b < KEY_W / 8; b++) begin
      byte_v = raw[8*b +: 8];
      if (b >= kb || byte_v == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        k[8*b +: 8] = byte_v;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: sv/tid_req_if.sv
// Request channel of the tag identifier table: valid/ready plus mode and key.
// Depends on tid_pkg for the payload widths.
`default_nettype none

interface tid_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [tid_pkg::KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

`default_nettype wire

// File: sv/tid_rsp_if.sv
// Response channel of the tag identifier table: valid/ready plus hit and count.
// Depends on tid_pkg for the payload widths.
`default_nettype none

interface tid_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [tid_pkg::COUNT_W-1:0] count;

  modport source (output valid, output hit, output count, input ready);
  modport sink   (input valid, input hit, input count, output ready);
endinterface

`default_nettype wire

// File: sv/tid_cell.sv
// One cell of the tag table chain: holds one entry, compares it with the key,
// extends the first-match chain and shifts down from its upper neighbor.
// Depends on tid_pkg.
`default_nettype none

module tid_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire logic                      clk_i,
  input  wire logic [tid_pkg::KEY_W-1:0] key_i,
  input  wire logic [CW-1:0]             count_i,
  input  wire tid_pkg::cell_ctl_t        ctl_i,
  input  wire logic                      found_i,
  input  wire logic [tid_pkg::KEY_W-1:0] next_i,
  output logic                           found_o,
  output logic [tid_pkg::KEY_W-1:0]      entry_o
);

  logic [tid_pkg::KEY_W-1:0] entry_q, entry_d;
  logic                      valid;
  logic                      eq;
  logic                      at_fill;

  // Match only on occupied entries; the chain marks this cell and all above
  // the first match.
  assign valid   = CW'(IDX) < count_i;
  assign at_fill = CW'(IDX) == count_i;
  assign eq      = valid && (entry_q == key_i);
  assign found_o = found_i | eq;
  assign entry_o = entry_q;

  // Append at the fill position, or close the gap left by a removal.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.add_en && at_fill) begin
      entry_d = key_i;
    end else if (ctl_i.rem_en && found_o) begin
      entry_d = next_i;
    end
  end

  // Entry storage needs no reset: it is read only below the count.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// File: sv/tag_id_table.sv
// Top level of the tag identifier table: request/response handshake,
// sequencing, entry count and the chain of tid_cell instances.
// Depends on tid_pkg, tid_req_if, tid_rsp_if and tid_cell.
`default_nettype none

// An ordered table of up to DEPTH tag identifiers held in a row of cells,
// one entry per cell. A request is accepted in the idle state, which registers
// the normalized key; the exec state then compares it in all cells
// at once, ripples the first-match flag along the chain, performs the add,
// shift-down removal or clear, and loads the response register. The response
// register lets the next request be accepted while a result waits; if the
// previous result is still untaken, the exec state waits for it. A new request
// is accepted only once the exec state of the last one is done.
// The path that sets the cycle time is the key compare plus the first-match
// ripple through all DEPTH cells. No clearing pass is needed after reset.

module tag_id_table #(
  parameter int unsigned DEPTH     = tid_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BYTES = tid_pkg::KEY_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tid_req_if.sink    req_i,
  tid_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                      state_q, state_d;
  tid_pkg::mode_e            mode_q;
  logic [tid_pkg::KEY_W-1:0] key_q;
  logic [CW-1:0]             count_q, count_d;
  logic                      rsp_valid_q, rsp_valid_d;
  logic                      rsp_hit_q, rsp_hit_d;
  logic                      accept;
  logic                      exec;
  logic                      hit;
  tid_pkg::cell_ctl_t        ctl;

  logic                      found_w [DEPTH+1];
  logic [tid_pkg::KEY_W-1:0] entry_w [DEPTH];

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign exec        = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign hit         = found_w[DEPTH];

  // Latch the request with its key already normalized.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= tid_pkg::mode_e'(req_i.mode);
      key_q  <= tid_pkg::norm_key(req_i.key, KEY_BYTES);
    end
  end

  // Operation decode: cell controls, next count and the hit flag.
  always_comb begin
    ctl       = '0;
    count_d   = count_q;
    rsp_hit_d = rsp_hit_q;
    if (exec) begin
      case (mode_q)
        tid_pkg::MODE_ADD: begin
          if (count_q < CW'(DEPTH)) begin
            ctl.add_en = 1'b1;
            count_d    = count_q + CW'(1);
            rsp_hit_d  = 1'b1;
          end else begin
            rsp_hit_d = 1'b0;
          end
        end
        tid_pkg::MODE_FIND: begin
          rsp_hit_d = hit;
        end
        tid_pkg::MODE_REMOVE: begin
          rsp_hit_d = hit;
          if (hit) begin
            ctl.rem_en = 1'b1;
            count_d    = count_q - CW'(1);
          end
        end
        tid_pkg::MODE_CLEAR: begin
          count_d   = '0;
          rsp_hit_d = 1'b0;
        end
        default: begin
          rsp_hit_d = 1'b0;
        end
      endcase
    end
  end

  // Sequencer and response valid.
  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec) begin
          state_d     = ST_IDLE;
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // The hit flag is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    rsp_hit_q <= rsp_hit_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit   = rsp_hit_q;
  assign rsp_o.count = tid_pkg::COUNT_W'(count_q);

  // Chain of cells; the first-match flag ripples from cell 0 upward.
  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [tid_pkg::KEY_W-1:0] next_entry;
    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    tid_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .key_i   (key_q),
      .count_i (count_q),
      .ctl_i   (ctl),
      .found_i (found_w[i]),
      .next_i  (next_entry),
      .found_o (found_w[i+1]),
      .entry_o (entry_w[i])
    );
  end

endmodule

`default_nettype wire
